// File: hw/rtl/fum_pkg.sv
// Package for the fisheye undistortion coordinate map.
// Field widths, register indexes, payload structs and the CORDIC angle table.
// No dependencies.
`default_nettype none

package fum_pkg;

	localparam int PIX_W      = 12;
	localparam int SRC_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int SIZE_W     = 24;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Dividend width of the scale divider: |td| (37 bits) shifted up by 20
	localparam int DIV_W = 57;

	localparam int CORDIC_ITER = 30;

	localparam logic [30:0]        UV_SAT      = 31'h7FFF_FFFF;
	localparam logic signed [32:0] HALF_PI_Q30 = 33'sh0_6487_ED51;

	// atan(2^-i) in Q.30, truncated
	localparam logic [31:0] ATAN_TAB [CORDIC_ITER] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAM_FOCAL      = 3'd0,
		CFG_CAM_CENTER     = 3'd1,
		CFG_RECT_FOCAL_INV = 3'd2,
		CFG_RECT_CENTER    = 3'd3,
		CFG_DIST_K12       = 3'd4,
		CFG_DIST_K34       = 3'd5,
		CFG_SOURCE_SIZE    = 3'd6
	} cfg_idx_t;

	// Normalised point and out-of-frame flag, carried down the pipe
	typedef struct packed {
		logic               oob;
		logic signed [31:0] u;
		logic signed [31:0] v;
	} uv_tag_t;

	typedef struct packed {
		uv_tag_t     uv;
		logic [31:0] r;
	} geo_tag_t;

	typedef struct packed {
		uv_tag_t uv;
		logic    neg;
		logic    rzero;
	} div_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/fum_if.sv
// Valid/ready channel interfaces for rectified input and source output beats.
// Depends on fum_pkg.
`default_nettype none

interface fum_rect_if import fum_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] rect_x;
	logic [PIX_W-1:0] rect_y;

	modport source (output valid, output rect_x, output rect_y, input ready);
	modport sink   (input valid, input rect_x, input rect_y, output ready);
endinterface

interface fum_src_if import fum_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SRC_W-1:0] src_x;
	logic [SRC_W-1:0] src_y;
	logic             in_bounds;

	modport source (output valid, output src_x, output src_y, output in_bounds, input ready);
	modport sink   (input valid, input src_x, input src_y, input in_bounds, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fisheye_undistort_coord_map_core.sv
// Pipeline stages from input beat to result beat: 5 normalise, 32 sqrt,
// 30 CORDIC, 9 polynomial, 57 divider, 6 projection/output stages.
// Throughput: one beat per clock; the pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage.
// Reset: arst_n clears all valid bits and every configuration register to zero.
// Depends on fum_pkg, fum_if, fum_isqrt, fum_cordic, fum_div.
`default_nettype none

module fisheye_undistort_coord_map_core import fum_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	fum_rect_if.sink                   coord_in,
	fum_src_if.source                  coord_out
);

	// ---------------------------------------------------------------
	// configuration registers
	logic [63:0]       cam_focal_q, cam_center_q, rect_focal_inv_q, rect_center_q;
	logic [63:0]       dist_k12_q, dist_k34_q;
	logic [SIZE_W-1:0] source_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_focal_q      <= '0;
			cam_center_q     <= '0;
			rect_focal_inv_q <= '0;
			rect_center_q    <= '0;
			dist_k12_q       <= '0;
			dist_k34_q       <= '0;
			source_size_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CAM_FOCAL:      cam_focal_q      <= cfg_wdata;
				CFG_CAM_CENTER:     cam_center_q     <= cfg_wdata;
				CFG_RECT_FOCAL_INV: rect_focal_inv_q <= cfg_wdata;
				CFG_RECT_CENTER:    rect_center_q    <= cfg_wdata;
				CFG_DIST_K12:       dist_k12_q       <= cfg_wdata;
				CFG_DIST_K34:       dist_k34_q       <= cfg_wdata;
				CFG_SOURCE_SIZE:    source_size_q    <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// global advance: whole pipe moves unless the output beat is stuck
	logic en;
	logic vld_s20;

	assign en             = !vld_s20 || coord_out.ready;
	assign coord_in.ready = en;

	// ---------------------------------------------------------------
	// s1: offset from the rectified centre, Q.16
	logic               vld_s1, oob_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [32:0] dx, dy;
	logic               oob_in;

	assign dx = $signed({5'd0, coord_in.rect_x, 16'd0}) - $signed({1'b0, rect_center_q[31:0]});
	assign dy = $signed({5'd0, coord_in.rect_y, 16'd0}) - $signed({1'b0, rect_center_q[63:32]});
	assign oob_in = (32'(coord_in.rect_x) >= 32'(MAX_WIDTH))
	             || (32'(coord_in.rect_y) >= 32'(MAX_HEIGHT));

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s1 <= oob_in;
			dx_s1  <= dx;
			dy_s1  <= dy;
		end
	end

	// s2: magnitude times reciprocal focal
	logic        vld_s2, oob_s2, negx_s2, negy_s2;
	logic [64:0] prodx_s2, prody_s2;
	logic [32:0] magx, magy;

	assign magx = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign magy = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s2   <= oob_s1;
			negx_s2  <= dx_s1[32];
			negy_s2  <= dy_s1[32];
			prodx_s2 <= magx * rect_focal_inv_q[31:0];
			prody_s2 <= magy * rect_focal_inv_q[63:32];
		end
	end

	// s3: Q.20 with saturation, sign restored
	logic               vld_s3, oob_s3;
	logic [30:0]        qmx_s3, qmy_s3;
	logic signed [31:0] u_s3, v_s3;
	logic [38:0]        qrawx, qrawy;
	logic [30:0]        qmx, qmy;

	assign qrawx = prodx_s2[64:26];
	assign qrawy = prody_s2[64:26];
	assign qmx   = (qrawx > 39'(UV_SAT)) ? UV_SAT : qrawx[30:0];
	assign qmy   = (qrawy > 39'(UV_SAT)) ? UV_SAT : qrawy[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s3 <= oob_s2;
			qmx_s3 <= qmx;
			qmy_s3 <= qmy;
			u_s3   <= negx_s2 ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
			v_s3   <= negy_s2 ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});
		end
	end

	// s4: squares
	logic        vld_s4;
	uv_tag_t     uv_s4;
	logic [61:0] sqx_s4, sqy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s4  <= '{oob: oob_s3, u: u_s3, v: v_s3};
			sqx_s4 <= qmx_s3 * qmx_s3;
			sqy_s4 <= qmy_s3 * qmy_s3;
		end
	end

	// s5: radius squared
	logic        vld_s5;
	uv_tag_t     uv_s5;
	logic [62:0] rad_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s5  <= uv_s4;
			rad_s5 <= 63'(sqx_s4) + 63'(sqy_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coord_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// ---------------------------------------------------------------
	// radius and angle
	logic               sq_vld;
	logic [31:0]        sq_root;
	uv_tag_t            sq_tag;
	logic               cd_vld;
	logic signed [32:0] cd_z;
	geo_tag_t           cd_tag;
	geo_tag_t           cd_tag_in;

	fum_isqrt #(
		.TAG_W ($bits(uv_tag_t))
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s5),
		.rad_i  ({1'b0, rad_s5}),
		.tag_i  (uv_s5),
		.vld_o  (sq_vld),
		.root_o (sq_root),
		.tag_o  (sq_tag)
	);

	assign cd_tag_in = '{uv: sq_tag, r: sq_root};

	fum_cordic #(
		.TAG_W ($bits(geo_tag_t))
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (sq_vld),
		.r_i    (sq_root),
		.tag_i  (cd_tag_in),
		.vld_o  (cd_vld),
		.z_o    (cd_z),
		.tag_o  (cd_tag)
	);

	// ---------------------------------------------------------------
	// s6: clamp to [0, pi/2], take theta to Q.24
	logic        vld_s6;
	geo_tag_t    geo_s6;
	logic [24:0] th_s6;
	logic signed [32:0] zc;

	always_comb begin
		if (cd_z < 0) begin
			zc = '0;
		end else if (cd_z > HALF_PI_Q30) begin
			zc = HALF_PI_Q30;
		end else begin
			zc = cd_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6 <= cd_tag;
			th_s6  <= zc[30:6];
		end
	end

	// s7: theta^2
	logic        vld_s7;
	geo_tag_t    geo_s7;
	logic [24:0] th_s7;
	logic [25:0] t2_s7;
	logic [49:0] th_sq;

	assign th_sq = th_s6 * th_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s7 <= geo_s6;
			th_s7  <= th_s6;
			t2_s7  <= th_sq[49:24];
		end
	end

	// s8: theta^4
	logic        vld_s8;
	geo_tag_t    geo_s8;
	logic [24:0] th_s8;
	logic [25:0] t2_s8;
	logic [26:0] t4_s8;
	logic [51:0] t2_sq;

	assign t2_sq = t2_s7 * t2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s8 <= geo_s7;
			th_s8  <= th_s7;
			t2_s8  <= t2_s7;
			t4_s8  <= t2_sq[50:24];
		end
	end

	// s9: theta^6 and theta^8
	logic        vld_s9;
	geo_tag_t    geo_s9;
	logic [24:0] th_s9;
	logic [25:0] t2_s9;
	logic [26:0] t4_s9;
	logic [27:0] t6_s9;
	logic [29:0] t8_s9;
	logic [52:0] t42;
	logic [53:0] t44;

	assign t42 = t4_s8 * t2_s8;
	assign t44 = t4_s8 * t4_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s9 <= geo_s8;
			th_s9  <= th_s8;
			t2_s9  <= t2_s8;
			t4_s9  <= t4_s8;
			t6_s9  <= t42[51:24];
			t8_s9  <= t44[53:24];
		end
	end

	// s10: coefficient products
	logic               vld_s10;
	geo_tag_t           geo_s10;
	logic [24:0]        th_s10;
	logic signed [63:0] m1_s10, m2_s10, m3_s10, m4_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s10 <= geo_s9;
			th_s10  <= th_s9;
			m1_s10  <= $signed(dist_k12_q[31:0])  * $signed({1'b0, t2_s9});
			m2_s10  <= $signed(dist_k12_q[63:32]) * $signed({1'b0, t4_s9});
			m3_s10  <= $signed(dist_k34_q[31:0])  * $signed({1'b0, t6_s9});
			m4_s10  <= $signed(dist_k34_q[63:32]) * $signed({1'b0, t8_s9});
		end
	end

	// s11: pairwise sums
	logic               vld_s11;
	geo_tag_t           geo_s11;
	logic [24:0]        th_s11;
	logic signed [63:0] sa_s11, sb_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s11 <= geo_s10;
			th_s11  <= th_s10;
			sa_s11  <= m1_s10 + m2_s10;
			sb_s11  <= m3_s10 + m4_s10;
		end
	end

	// s12: polynomial, Q.28
	logic               vld_s12;
	geo_tag_t           geo_s12;
	logic [24:0]        th_s12;
	logic signed [39:0] poly_s12;
	logic signed [63:0] acc;

	assign acc = sa_s11 + sb_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s12  <= geo_s11;
			th_s12   <= th_s11;
			poly_s12 <= $signed({11'd0, 1'b1, 28'd0}) + $signed(acc[63:24]);
		end
	end

	// s13: theta * poly
	logic               vld_s13;
	geo_tag_t           geo_s13;
	logic signed [65:0] tp_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s13 <= geo_s12;
			tp_s13  <= $signed({1'b0, th_s12}) * poly_s12;
		end
	end

	// s14: distorted angle, magnitude into the divider
	logic               vld_s14;
	div_tag_t           dtag_s14;
	logic [31:0]        r_s14;
	logic [DIV_W-1:0]   num_s14;
	logic signed [37:0] td;
	logic [37:0]        td_mag;

	assign td     = tp_s13[65:28];
	assign td_mag = td[37] ? 38'(-td) : 38'(td);

	always_ff @(posedge clk) begin
		if (en) begin
			dtag_s14 <= '{uv: geo_s13.uv, neg: td[37], rzero: (geo_s13.r == '0)};
			r_s14    <= geo_s13.r;
			num_s14  <= {td_mag[36:0], 20'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s6  <= cd_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// ---------------------------------------------------------------
	// scale = td * 2^20 / r
	logic             dv_vld;
	logic [DIV_W-1:0] dv_quo;
	div_tag_t         dv_tag;

	fum_div #(
		.TAG_W ($bits(div_tag_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s14),
		.num_i  (num_s14),
		.den_i  (r_s14),
		.tag_i  (dtag_s14),
		.vld_o  (dv_vld),
		.quo_o  (dv_quo),
		.tag_o  (dv_tag)
	);

	// s15: signed scale, unity for a zero radius
	logic        vld_s15;
	uv_tag_t     uv_s15;
	logic [63:0] scale_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s15 <= dv_tag.uv;
			if (dv_tag.rzero) begin
				scale_s15 <= 64'd1 << 24;
			end else if (dv_tag.neg) begin
				scale_s15 <= -{{(64-DIV_W){1'b0}}, dv_quo};
			end else begin
				scale_s15 <= {{(64-DIV_W){1'b0}}, dv_quo};
			end
		end
	end

	// s16: u*scale modulo 2^64, as low and high partial products
	logic               vld_s16;
	logic               oob_s16;
	logic signed [64:0] lox_s16, loy_s16;
	logic [31:0]        hix_s16, hiy_s16;

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s16 <= uv_s15.oob;
			lox_s16 <= uv_s15.u * $signed({1'b0, scale_s15[31:0]});
			loy_s16 <= uv_s15.v * $signed({1'b0, scale_s15[31:0]});
			hix_s16 <= uv_s15.u * scale_s15[63:32];
			hiy_s16 <= uv_s15.v * scale_s15[63:32];
		end
	end

	// s17: warped point, Q.20
	logic        vld_s17, oob_s17;
	logic [39:0] wx_s17, wy_s17;
	logic [63:0] px, py;

	assign px = lox_s16[63:0] + {hix_s16, 32'd0};
	assign py = loy_s16[63:0] + {hiy_s16, 32'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s17 <= oob_s16;
			wx_s17  <= px[63:24];
			wy_s17  <= py[63:24];
		end
	end

	// s18: focal products modulo 2^64
	logic        vld_s18, oob_s18;
	logic [63:0] fxl_s18, fyl_s18;
	logic [31:0] fxh_s18, fyh_s18;

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s18 <= oob_s17;
			fxl_s18 <= cam_focal_q[31:0]  * wx_s17[31:0];
			fyl_s18 <= cam_focal_q[63:32] * wy_s17[31:0];
			fxh_s18 <= cam_focal_q[31:0]  * {{24{wx_s17[39]}}, wx_s17[39:32]};
			fyh_s18 <= cam_focal_q[63:32] * {{24{wy_s17[39]}}, wy_s17[39:32]};
		end
	end

	// s19: add the source centre, Q.36
	logic        vld_s19, oob_s19;
	logic [63:0] ox_s19, oy_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s19 <= oob_s18;
			ox_s19  <= fxl_s18 + {fxh_s18, 32'd0} + {12'd0, cam_center_q[31:0], 20'd0};
			oy_s19  <= fyl_s18 + {fyh_s18, 32'd0} + {12'd0, cam_center_q[63:32], 20'd0};
		end
	end

	// s20: bounds check, output register
	logic             in_bounds_s20;
	logic [SRC_W-1:0] src_x_s20, src_y_s20;
	logic signed [12:0] wl, hl;
	logic signed [63:0] xlim, ylim;
	logic               ok;

	assign wl   = $signed({1'b0, source_size_q[11:0]}) - 13'sd1;
	assign hl   = $signed({1'b0, source_size_q[23:12]}) - 13'sd1;
	assign xlim = {{15{wl[12]}}, wl, 36'd0};
	assign ylim = {{15{hl[12]}}, hl, 36'd0};
	assign ok   = !oob_s19
	           && ($signed(ox_s19) > 64'sd0) && ($signed(oy_s19) > 64'sd0)
	           && ($signed(ox_s19) < xlim) && ($signed(oy_s19) < ylim);

	always_ff @(posedge clk) begin
		if (en) begin
			in_bounds_s20 <= ok;
			src_x_s20     <= ok ? ox_s19[47:28] : '0;
			src_y_s20     <= ok ? oy_s19[47:28] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
			vld_s20 <= 1'b0;
		end else if (en) begin
			vld_s15 <= dv_vld;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
			vld_s19 <= vld_s18;
			vld_s20 <= vld_s19;
		end
	end

	assign coord_out.valid     = vld_s20;
	assign coord_out.src_x     = src_x_s20;
	assign coord_out.src_y     = src_y_s20;
	assign coord_out.in_bounds = in_bounds_s20;

	// ---------------------------------------------------------------
	// checks
	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		coord_out.valid && !coord_out.in_bounds |->
			coord_out.src_x == '0 && coord_out.src_y == '0)
		else $error("out-of-frame beat carries a nonzero coordinate");

	a_x_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		coord_out.valid && coord_out.in_bounds |->
			(32'(coord_out.src_x) < ((32'(source_size_q[11:0]) - 32'd1) << 8)))
		else $error("in-bounds column at or beyond W-1");

	a_oob_flag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s19 && oob_s19 && en |=> coord_out.valid && !coord_out.in_bounds)
		else $error("rectified pixel outside the frame reported in bounds");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s14) && $stable(vld_s5))
		else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire

// File: hw/rtl/fum_isqrt.sv
// Pipelined integer square root, one result bit per stage (32 stages).
// Sideband tag travels alongside. No package dependency.
`default_nettype none

module fum_isqrt #(
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [63:0]      rad_i,
	input  wire logic [TAG_W-1:0] tag_i,
	output logic                  vld_o,
	output logic [31:0]           root_o,
	output logic [TAG_W-1:0]      tag_o
);
	localparam int STEPS = 32;

	logic             vld_s  [STEPS];
	logic [63:0]      rad_s  [STEPS];
	logic [35:0]      rem_s  [STEPS];
	logic [31:0]      root_s [STEPS];
	logic [TAG_W-1:0] tag_s  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic             vld_p;
		logic [63:0]      rad_p;
		logic [35:0]      rem_p;
		logic [31:0]      root_p;
		logic [TAG_W-1:0] tag_p;
		logic [35:0]      rem_sh;
		logic [35:0]      trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_p  = vld_i;
			assign rad_p  = rad_i;
			assign rem_p  = '0;
			assign root_p = '0;
			assign tag_p  = tag_i;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign tag_p  = tag_s[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign rem_sh = {rem_p[33:0], rad_p[63:62]};
		assign trial  = {2'b00, root_p, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[61:0], 2'b00};
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_p[30:0], ge};
				tag_s[k]  <= tag_p;
			end
		end
	end

	assign vld_o  = vld_s[STEPS-1];
	assign root_o = root_s[STEPS-1];
	assign tag_o  = tag_s[STEPS-1];

endmodule

`default_nettype wire

// File: hw/rtl/fum_cordic.sv
// Pipelined CORDIC in vectoring mode: atan(r) in Q.30, one iteration per stage.
// Depends on fum_pkg for the angle table and iteration count.
`default_nettype none

module fum_cordic import fum_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [31:0]      r_i,
	input  wire logic [TAG_W-1:0] tag_i,
	output logic                  vld_o,
	output logic signed [32:0]    z_o,
	output logic [TAG_W-1:0]      tag_o
);
	localparam int ITER = CORDIC_ITER;

	logic                vld_s [ITER];
	logic signed [45:0]  x_s   [ITER];
	logic signed [45:0]  y_s   [ITER];
	logic signed [32:0]  z_s   [ITER];
	logic [TAG_W-1:0]    tag_s [ITER];

	for (genvar k = 0; k < ITER; k++) begin : g_iter
		logic               vld_p;
		logic signed [45:0] x_p;
		logic signed [45:0] y_p;
		logic signed [32:0] z_p;
		logic [TAG_W-1:0]   tag_p;
		logic signed [45:0] xs;
		logic signed [45:0] ys;
		logic signed [32:0] at;

		if (k == 0) begin : g_first
			assign vld_p = vld_i;
			assign x_p   = {15'd0, 1'b1, 30'd0};
			assign y_p   = {4'd0, r_i, 10'd0};
			assign z_p   = '0;
			assign tag_p = tag_i;
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign x_p   = x_s[k-1];
			assign y_p   = y_s[k-1];
			assign z_p   = z_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign xs = x_p >>> k;
		assign ys = y_p >>> k;
		assign at = $signed({1'b0, ATAN_TAB[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		// rotate towards the x axis, accumulate the angle
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_p[45]) begin
					x_s[k] <= x_p + ys;
					y_s[k] <= y_p - xs;
					z_s[k] <= z_p + at;
				end else begin
					x_s[k] <= x_p - ys;
					y_s[k] <= y_p + xs;
					z_s[k] <= z_p - at;
				end
				tag_s[k] <= tag_p;
			end
		end
	end

	assign vld_o = vld_s[ITER-1];
	assign z_o   = z_s[ITER-1];
	assign tag_o = tag_s[ITER-1];

endmodule

`default_nettype wire

// File: hw/rtl/fum_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the radial scale.
// Depends on fum_pkg for the dividend width.
`default_nettype none

module fum_div import fum_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [DIV_W-1:0] num_i,
	input  wire logic [31:0]      den_i,
	input  wire logic [TAG_W-1:0] tag_i,
	output logic                  vld_o,
	output logic [DIV_W-1:0]      quo_o,
	output logic [TAG_W-1:0]      tag_o
);
	logic             vld_s [DIV_W];
	logic [DIV_W-1:0] num_s [DIV_W];
	logic [DIV_W-1:0] quo_s [DIV_W];
	logic [31:0]      rem_s [DIV_W];
	logic [31:0]      den_s [DIV_W];
	logic [TAG_W-1:0] tag_s [DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_bit
		logic             vld_p;
		logic [DIV_W-1:0] num_p;
		logic [DIV_W-1:0] quo_p;
		logic [31:0]      rem_p;
		logic [31:0]      den_p;
		logic [TAG_W-1:0] tag_p;
		logic [32:0]      rem_sh;
		logic [32:0]      diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_p = vld_i;
			assign num_p = num_i;
			assign quo_p = '0;
			assign rem_p = '0;
			assign den_p = den_i;
			assign tag_p = tag_i;
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign rem_sh = {rem_p, num_p[DIV_W-1]};
		assign diff   = rem_sh - {1'b0, den_p};
		assign ge     = (rem_sh >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= {num_p[DIV_W-2:0], 1'b0};
				quo_s[k] <= {quo_p[DIV_W-2:0], ge};
				rem_s[k] <= ge ? diff[31:0] : rem_sh[31:0];
				den_s[k] <= den_p;
				tag_s[k] <= tag_p;
			end
		end
	end

	assign vld_o = vld_s[DIV_W-1];
	assign quo_o = quo_s[DIV_W-1];
	assign tag_o = tag_s[DIV_W-1];

endmodule

`default_nettype wire
